@@ rtl/core/pmtu_pkg.sv @@
// Shared types and constants for the privileged mode transition unit.
package pmtu_pkg;

    // Event codes carried in the func field
    typedef enum logic [2:0] {
        FUNC_RETURN    = 3'd0,
        FUNC_INTERRUPT = 3'd1,
        FUNC_EXC_NORM  = 3'd2,
        FUNC_EXC_SEVERE = 3'd3,
        FUNC_CHM       = 3'd4
    } func_t;

    // Fault codes reported with each result
    typedef enum logic [1:0] {
        FLT_NONE    = 2'd0,
        FLT_RSVD_OP = 2'd1,
        FLT_VEC_HLT = 2'd2,
        FLT_CHM_IS  = 2'd3
    } fault_t;

    // Status longword layout
    localparam int unsigned PSL_CM      = 31;
    localparam int unsigned PSL_TP      = 30;
    localparam int unsigned PSL_IS      = 26;
    localparam int unsigned PSL_CUR_LO  = 24;
    localparam int unsigned PSL_PRV_LO  = 22;
    localparam int unsigned PSL_IPL_LO  = 16;
    localparam logic [31:0] PSL_MBZ_MASK = 32'h3020_FF00;
    localparam logic [31:0] PSL_RESET    = 32'h041F_0000;

    // Stack bank: four modes plus the interrupt stack
    localparam int unsigned BANK_DEPTH = 5;
    localparam logic [2:0]  BANK_IDX_INT = 3'd4;
    localparam logic [2:0]  BANK_IDX_KERNEL = 3'd0;

    // Configuration register map
    localparam logic [1:0] CFG_ADDR_AST_LEVEL = 2'd0;
    localparam logic [2:0] AST_LEVEL_RESET = 3'd4;

    // Stream widths
    localparam int unsigned S_TDATA_W = 160;
    localparam int unsigned M_TDATA_W = 200;

endpackage

@@ rtl/core/privileged_mode_transition_unit.sv @@
// Privileged mode transition unit: return, interrupt, exception and change-mode handling.
// A beat goes through the input register, combinational logic, then the result register.
// Throughput: one event per cycle unless m_tready stalls; all work is one combinational pass.
// State updates as an event moves to the result register, so each event sees its predecessor.
// Reset (aresetn, synchronous, active low): kernel mode on the interrupt stack at IPL 31,
// stack pointer and bank cleared, trap delivery level 4, both stream registers empty.
module privileged_mode_transition_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // tdata: func[2:0], chm_mode[4:3], new_ipl[9:5], vector_word[41:10],
    //        popped_pc[73:42], popped_psl[105:74], return_pc[137:106],
    //        chm_code[153:138], zero[159:154]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pmtu_pkg::S_TDATA_W-1:0] s_tdata,
    // tdata: fault[1:0], next_pc[33:2], next_psl[65:34], stack_top[97:66],
    //        push_count[99:98], push_first[131:100], push_second[163:132],
    //        push_third[195:164], ast_request[196], zero[199:197]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pmtu_pkg::M_TDATA_W-1:0] m_tdata,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [1:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import pmtu_pkg::*;

    // Input register
    logic        in_valid_reg;
    logic [2:0]  func_reg;
    logic [1:0]  chm_mode_reg;
    logic [4:0]  new_ipl_reg;
    logic [31:0] vector_word_reg;
    logic [31:0] popped_pc_reg;
    logic [31:0] popped_psl_reg;
    logic [31:0] return_pc_reg;
    logic [15:0] chm_code_reg;

    // Architectural state
    logic [31:0] psl_reg;
    logic [31:0] sp_reg;
    logic [31:0] bank_reg [BANK_DEPTH];
    logic [2:0]  ast_level_reg;

    // Result register
    logic        out_valid_reg;
    logic [1:0]  fault_reg;
    logic [31:0] next_pc_reg;
    logic [31:0] next_psl_reg;
    logic [31:0] stack_top_reg;
    logic [1:0]  push_count_reg;
    logic [31:0] push_first_reg;
    logic [31:0] push_second_reg;
    logic [31:0] push_third_reg;
    logic        ast_request_reg;

    // Combinational results
    logic        advance;
    logic        state_we;
    logic [31:0] psl_next;
    logic [31:0] sp_next;
    logic        bank_we;
    logic [2:0]  bank_wr_idx;
    logic [31:0] bank_wr_data;
    logic [2:0]  bank_rd_idx;
    logic [31:0] bank_rd_data;
    logic [31:0] bank_rd_data_raw;
    logic [1:0]  fault_next;
    logic [31:0] next_pc_next;
    logic [1:0]  push_count_next;
    logic [31:0] push_first_next;
    logic [31:0] push_second_next;
    logic [31:0] push_third_next;
    logic        ast_request_next;

    // Decoded pieces of the current and popped status longwords
    logic [1:0]  old_mode;
    logic [4:0]  old_ipl;
    logic        old_is;
    logic [1:0]  ret_mode;
    logic [1:0]  ret_prv;
    logic [4:0]  ret_ipl;
    logic        ret_bad;
    logic [31:0] ent_pc;
    logic [1:0]  chm_tgt;
    logic [31:0] sp_plus8;

    assign old_mode = psl_reg[PSL_CUR_LO +: 2];
    assign old_ipl  = psl_reg[PSL_IPL_LO +: 5];
    assign old_is   = psl_reg[PSL_IS];
    assign ret_mode = popped_psl_reg[PSL_CUR_LO +: 2];
    assign ret_prv  = popped_psl_reg[PSL_PRV_LO +: 2];
    assign ret_ipl  = popped_psl_reg[PSL_IPL_LO +: 5];
    assign sp_plus8 = sp_reg + 32'd8;
    assign ent_pc   = {vector_word_reg[31:1],
                       vector_word_reg[0] | (func_reg == FUNC_EXC_SEVERE)};
    assign chm_tgt  = (old_mode < chm_mode_reg) ? old_mode : chm_mode_reg;

    // Handshake: the input register moves on when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr == CFG_ADDR_AST_LEVEL) ? {29'd0, ast_level_reg} : 32'd0;

    // Popped status longword checks for return
    always_comb begin
        ret_bad = 1'b0;
        if ((popped_psl_reg & PSL_MBZ_MASK) != 32'd0 || ret_mode < old_mode) begin
            ret_bad = 1'b1;
        end
        if (ret_mode != 2'd0) begin
            if (popped_psl_reg[PSL_IS] || ret_ipl != 5'd0 || ret_mode > ret_prv) begin
                ret_bad = 1'b1;
            end
        end else begin
            if (popped_psl_reg[PSL_IS] && (!old_is || ret_ipl == 5'd0)) begin
                ret_bad = 1'b1;
            end
            if (ret_ipl > old_ipl) begin
                ret_bad = 1'b1;
            end
        end
        if (popped_psl_reg[PSL_CM]) begin
            ret_bad = 1'b1;
        end
    end

    // Bank read with forwarding of this event's own bank write
    assign bank_rd_data_raw = bank_reg[bank_rd_idx];
    assign bank_rd_data = (bank_we && bank_wr_idx == bank_rd_idx) ? bank_wr_data
                                                                  : bank_rd_data_raw;

    // Event evaluation
    always_comb begin
        state_we         = 1'b0;
        psl_next         = psl_reg;
        sp_next          = sp_reg;
        bank_we          = 1'b0;
        bank_wr_idx      = {1'b0, old_mode};
        bank_wr_data     = sp_reg;
        bank_rd_idx      = BANK_IDX_KERNEL;
        fault_next       = FLT_NONE;
        next_pc_next     = 32'd0;
        push_count_next  = 2'd0;
        push_first_next  = 32'd0;
        push_second_next = 32'd0;
        push_third_next  = 32'd0;
        ast_request_next = 1'b0;
        unique case (func_reg)
            FUNC_RETURN: begin
                if (ret_bad) begin
                    fault_next = FLT_RSVD_OP;
                end else begin
                    state_we     = 1'b1;
                    bank_we      = 1'b1;
                    bank_wr_idx  = old_is ? BANK_IDX_INT : {1'b0, old_mode};
                    bank_wr_data = sp_plus8;
                    bank_rd_idx  = {1'b0, ret_mode};
                    psl_next     = popped_psl_reg | {1'b0, psl_reg[PSL_TP], 30'd0};
                    next_pc_next = popped_pc_reg;
                    if (popped_psl_reg[PSL_IS]) begin
                        sp_next = sp_plus8;
                    end else begin
                        sp_next          = bank_rd_data;
                        ast_request_next = ({1'b0, ret_mode} >= ast_level_reg);
                    end
                end
            end
            FUNC_INTERRUPT, FUNC_EXC_NORM, FUNC_EXC_SEVERE: begin
                if (ent_pc[1]) begin
                    fault_next = FLT_VEC_HLT;
                end else begin
                    state_we    = 1'b1;
                    bank_we     = !old_is;
                    bank_rd_idx = ent_pc[0] ? BANK_IDX_INT : BANK_IDX_KERNEL;
                    psl_next    = 32'd0;
                    if (old_is) begin
                        psl_next[PSL_IS] = 1'b1;
                        sp_next          = sp_reg - 32'd8;
                    end else begin
                        psl_next[PSL_IS] = ent_pc[0];
                        sp_next          = bank_rd_data - 32'd8;
                    end
                    if (func_reg == FUNC_INTERRUPT) begin
                        psl_next[PSL_IPL_LO +: 5] = new_ipl_reg;
                    end else begin
                        psl_next[PSL_IPL_LO +: 5] = ent_pc[0] ? 5'h1F : old_ipl;
                        psl_next[PSL_PRV_LO +: 2] = old_mode;
                    end
                    next_pc_next     = {ent_pc[31:2], 2'b00};
                    push_count_next  = 2'd2;
                    push_first_next  = return_pc_reg;
                    push_second_next = psl_reg;
                end
            end
            FUNC_CHM: begin
                if (old_is) begin
                    fault_next = FLT_CHM_IS;
                end else begin
                    state_we    = 1'b1;
                    bank_we     = 1'b1;
                    bank_rd_idx = {1'b0, chm_tgt};
                    sp_next     = bank_rd_data - 32'd12;
                    psl_next    = 32'd0;
                    psl_next[PSL_IPL_LO +: 5] = old_ipl;
                    psl_next[PSL_CUR_LO +: 2] = chm_tgt;
                    psl_next[PSL_PRV_LO +: 2] = old_mode;
                    next_pc_next     = {vector_word_reg[31:2], 2'b00};
                    push_count_next  = 2'd3;
                    push_first_next  = {{16{chm_code_reg[15]}}, chm_code_reg};
                    push_second_next = return_pc_reg;
                    push_third_next  = psl_reg;
                end
            end
            default: begin
                // Unused event codes leave state alone and report no fault
                fault_next = FLT_NONE;
            end
        endcase
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            func_reg        <= s_tdata[2:0];
            chm_mode_reg    <= s_tdata[4:3];
            new_ipl_reg     <= s_tdata[9:5];
            vector_word_reg <= s_tdata[41:10];
            popped_pc_reg   <= s_tdata[73:42];
            popped_psl_reg  <= s_tdata[105:74];
            return_pc_reg   <= s_tdata[137:106];
            chm_code_reg    <= s_tdata[153:138];
        end
    end

    // Architectural state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            psl_reg       <= PSL_RESET;
            sp_reg        <= 32'd0;
            ast_level_reg <= AST_LEVEL_RESET;
            for (int i = 0; i < BANK_DEPTH; i++) begin
                bank_reg[i] <= 32'd0;
            end
        end else begin
            if (psel && penable && pwrite && pready) begin
                ast_level_reg <= pwdata[2:0];
            end
            if (advance && state_we) begin
                psl_reg <= psl_next;
                sp_reg  <= sp_next;
                if (bank_we) begin
                    bank_reg[bank_wr_idx] <= bank_wr_data;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            fault_reg       <= fault_next;
            next_pc_reg     <= next_pc_next;
            next_psl_reg    <= psl_next;
            stack_top_reg   <= sp_next;
            push_count_reg  <= push_count_next;
            push_first_reg  <= push_first_next;
            push_second_reg <= push_second_next;
            push_third_reg  <= push_third_next;
            ast_request_reg <= ast_request_next;
        end
    end

    assign m_tdata = {3'd0, ast_request_reg, push_third_reg, push_second_reg,
                      push_first_reg, push_count_reg, stack_top_reg, next_psl_reg,
                      next_pc_reg, fault_reg};

`ifndef SYNTHESIS
    // A faulted beat carries no pushes and no trap request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && fault_reg != FLT_NONE) |-> (push_count_reg == 2'd0 && !ast_request_reg))
        else $error("faulted result carries pushes or trap request");

    // A fault leaves status longword and stack pointer untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && fault_next != FLT_NONE) |=> ($stable(psl_reg) && $stable(sp_reg)))
        else $error("state changed on a faulted event");

    // Trap requests only come with a status longword off the interrupt stack
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && ast_request_reg) |-> !next_psl_reg[PSL_IS])
        else $error("trap request while on interrupt stack");

    // The held status longword never has must-be-zero or compatibility bits set
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((psl_reg & PSL_MBZ_MASK) == 32'd0) && !psl_reg[PSL_CM])
        else $error("status longword holds reserved bits");
`endif

endmodule
